@@ hdl/abc_pkg.sv @@
`default_nettype none
package abc_pkg;

    localparam int STEP_BITS        = 24;
    localparam int WEIGHT_FRAC_BITS = 24;
    localparam int WEIGHT_W         = 32;
    localparam int ORDER_W          = 3;
    localparam int NUM_WEIGHTS      = 4;

    // linear step combinations (up to 11 * h), their pairwise products
    localparam int LIN_W  = STEP_BITS + 4;
    localparam int PRD_W  = 2 * LIN_W;
    localparam int HALF_W = (PRD_W + 1) / 2;
    localparam int HI_W   = PRD_W - HALF_W;

    // cubic numerators and denominators of the fourth-order weights
    localparam int NUM_W = 3 * STEP_BITS + 8;
    localparam int DEN_W = 3 * STEP_BITS + 7;

    // round(num * 2^F / den) = floor((num * 2^(F+1) + den) / (2 * den))
    localparam int QB    = WEIGHT_W;
    localparam int DVD_W = NUM_W + WEIGHT_FRAC_BITS + 2;
    localparam int DVS_W = DEN_W + 1;
    localparam int TOP_W = DVD_W - QB;
    localparam int CMP_W = (TOP_W > DVS_W) ? TOP_W : DVS_W;

    localparam int TERM_LAT = 6;
    localparam int DIV_LAT  = QB + 3;
    localparam int LAT      = TERM_LAT + DIV_LAT;

    localparam logic               MODE_ADAPT = 1'b1;
    localparam logic [ORDER_W-1:0] ORDER_ONE  = 3'd1;
    localparam logic [ORDER_W-1:0] ORDER_TWO  = 3'd2;
    localparam logic [ORDER_W-1:0] ORDER_THREE = 3'd3;
    localparam logic [ORDER_W-1:0] ORDER_MAX  = 3'd4;

    typedef logic [STEP_BITS-1:0]       step_t;
    typedef logic [ORDER_W-1:0]         order_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;

    typedef struct packed {
        logic   mode;
        order_t order;
        step_t  h0;
        step_t  h1;
        step_t  h2;
        step_t  h3;
    } req_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } frac_t;

    // equal-step weight magnitudes
    function automatic logic [5:0] const_num(input order_t order, input logic [1:0] k);
        logic [5:0] r;
        r = '0;
        case (order)
            3'd1: r = (k == 2'd0) ? 6'd1 : 6'd0;
            3'd2:
                case (k)
                    2'd0:    r = 6'd3;
                    2'd1:    r = 6'd1;
                    default: r = 6'd0;
                endcase
            3'd3:
                case (k)
                    2'd0:    r = 6'd23;
                    2'd1:    r = 6'd16;
                    2'd2:    r = 6'd5;
                    default: r = 6'd0;
                endcase
            3'd4:
                case (k)
                    2'd0:    r = 6'd55;
                    2'd1:    r = 6'd59;
                    2'd2:    r = 6'd37;
                    default: r = 6'd9;
                endcase
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] const_den(input order_t order);
        logic [4:0] r;
        r = 5'd1;
        case (order)
            3'd2:    r = 5'd2;
            3'd3:    r = 5'd12;
            3'd4:    r = 5'd24;
            default: r = 5'd1;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/abc_if.sv @@
`default_nettype none
interface abc_req_if;
    import abc_pkg::*;
    logic   valid;
    logic   ready;
    logic   mode;
    order_t order;
    step_t  step_now;
    step_t  step_back1;
    step_t  step_back2;
    step_t  step_back3;
    modport source (output valid, mode, order, step_now, step_back1, step_back2, step_back3,
                    input ready);
    modport sink (input valid, mode, order, step_now, step_back1, step_back2, step_back3,
                  output ready);
endinterface

interface abc_rsp_if;
    import abc_pkg::*;
    logic    valid;
    logic    ready;
    weight_t weight0;
    weight_t weight1;
    weight_t weight2;
    weight_t weight3;
    logic    error_flag;
    modport source (output valid, weight0, weight1, weight2, weight3, error_flag,
                    input ready);
    modport sink (input valid, weight0, weight1, weight2, weight3, error_flag,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/abc_terms.sv @@
`default_nettype none
module abc_terms (
    input  logic                                       clk,
    input  logic                                       adv,
    input  abc_pkg::req_t                              req,
    output abc_pkg::frac_t [abc_pkg::NUM_WEIGHTS-1:0] frac,
    output logic                                       perr
);
    import abc_pkg::*;

    typedef logic [LIN_W-1:0] lin_t;
    typedef logic [PRD_W-1:0] prd_t;

    typedef struct packed {
        logic   mode;
        order_t order;
        logic   perr;
        step_t  h0;
        logic [STEP_BITS+1:0] o2n0;
        logic [STEP_BITS:0]   o2d;
    } ctl_t;

    function automatic prd_t mul_ll(input lin_t a, input lin_t b);
        prd_t r;
        r = a * b;
        return r;
    endfunction

    // ---------------- stage 1: input register
    req_t r1_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg <= req;
        end
    end

    // ---------------- stage 2: quadratic products
    lin_t h0, h1, h2, h3;
    lin_t x0, x1, x2, x3, a12, a23, s123, q0l, u0, u1, u2;
    ctl_t c2_next;
    logic zero_need;

    always_comb
    begin
        h0   = LIN_W'(r1_reg.h0);
        h1   = LIN_W'(r1_reg.h1);
        h2   = LIN_W'(r1_reg.h2);
        h3   = LIN_W'(r1_reg.h3);
        x0   = LIN_W'(3 * h1 + 2 * h2 + h3);
        x1   = LIN_W'(2 * h1 + 2 * h2 + h3);
        x2   = LIN_W'(2 * h1 + h2 + h3);
        x3   = LIN_W'(2 * h1 + h2);
        a12  = h1 + h2;
        a23  = h2 + h3;
        s123 = h1 + h2 + h3;
        q0l  = LIN_W'(3 * h1 + 4 * h2 + 2 * h3);
        u0   = LIN_W'(2 * h0 + 6 * h1 + 3 * h2);
        u1   = LIN_W'(2 * h0 + 3 * h1 + 3 * h2);
        u2   = LIN_W'(2 * h0 + 3 * h1);
        zero_need = (r1_reg.h1 == '0)
                 || (r1_reg.order >= ORDER_THREE && r1_reg.h2 == '0)
                 || (r1_reg.order == ORDER_MAX && r1_reg.h3 == '0);
        c2_next.mode  = r1_reg.mode;
        c2_next.order = r1_reg.order;
        c2_next.perr  = (r1_reg.order > ORDER_MAX)
                     || (r1_reg.mode == MODE_ADAPT && r1_reg.order >= ORDER_TWO && zero_need);
        c2_next.h0    = r1_reg.h0;
        c2_next.o2n0  = (STEP_BITS+2)'(r1_reg.h0) + {1'b0, r1_reg.h1, 1'b0};
        c2_next.o2d   = {r1_reg.h1, 1'b0};
    end

    ctl_t c2_reg;
    prd_t sq_reg;
    prd_t hx_reg [4];
    prd_t y_reg  [4];
    prd_t e_reg  [4];
    prd_t t2_reg [3];
    lin_t l2_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_reg    <= c2_next;
            sq_reg    <= mul_ll(h0, h0);
            hx_reg[0] <= mul_ll(h0, x0);
            hx_reg[1] <= mul_ll(h0, x1);
            hx_reg[2] <= mul_ll(h0, x2);
            hx_reg[3] <= mul_ll(h0, x3);
            y_reg[0]  <= mul_ll(h1, q0l) + mul_ll(h2, a23);
            y_reg[1]  <= mul_ll(a12, s123);
            y_reg[2]  <= mul_ll(h1, s123);
            y_reg[3]  <= mul_ll(h1, a12);
            e_reg[0]  <= mul_ll(h1, a12);
            e_reg[1]  <= mul_ll(h1, h2);
            e_reg[2]  <= mul_ll(h2, a12);
            e_reg[3]  <= mul_ll(a23, s123);
            t2_reg[0] <= mul_ll(h0, u0);
            t2_reg[1] <= mul_ll(h0, u1);
            t2_reg[2] <= mul_ll(h0, u2);
            l2_reg[0] <= s123;
            l2_reg[1] <= a23;
            l2_reg[2] <= h3;
            l2_reg[3] <= h3;
        end
    end

    // ---------------- stage 3: quadratic sums, scaled denominators
    ctl_t c3_reg;
    prd_t p3_reg   [4];
    prd_t e12_3_reg [4];
    prd_t e6_3_reg  [3];
    prd_t t3_reg   [3];
    lin_t l3_reg   [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c3_reg <= c2_reg;
            for (int k = 0; k < 4; k++)
            begin
                p3_reg[k]    <= 3 * sq_reg + 4 * hx_reg[k] + 6 * y_reg[k];
                e12_3_reg[k] <= 12 * e_reg[k];
                l3_reg[k]    <= l2_reg[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                e6_3_reg[k] <= 6 * e_reg[k];
                t3_reg[k]   <= t2_reg[k];
            end
        end
    end

    // ---------------- stage 4: cubic partial products
    ctl_t c4_reg;
    logic [STEP_BITS+HALF_W-1:0] nlo_reg [4];
    logic [STEP_BITS+HI_W-1:0]   nhi_reg [4];
    logic [LIN_W+HALF_W-1:0]     dlo_reg [4];
    logic [LIN_W+HI_W-1:0]       dhi_reg [4];
    prd_t e6_4_reg [3];
    prd_t t4_reg   [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c4_reg <= c3_reg;
            for (int k = 0; k < 4; k++)
            begin
                nlo_reg[k] <= (STEP_BITS+HALF_W)'(c3_reg.h0)
                            * (STEP_BITS+HALF_W)'(p3_reg[k][HALF_W-1:0]);
                nhi_reg[k] <= (STEP_BITS+HI_W)'(c3_reg.h0)
                            * (STEP_BITS+HI_W)'(p3_reg[k][PRD_W-1:HALF_W]);
                dlo_reg[k] <= (LIN_W+HALF_W)'(l3_reg[k])
                            * (LIN_W+HALF_W)'(e12_3_reg[k][HALF_W-1:0]);
                dhi_reg[k] <= (LIN_W+HI_W)'(l3_reg[k])
                            * (LIN_W+HI_W)'(e12_3_reg[k][PRD_W-1:HALF_W]);
            end
            for (int k = 0; k < 3; k++)
            begin
                e6_4_reg[k] <= e6_3_reg[k];
                t4_reg[k]   <= t3_reg[k];
            end
        end
    end

    // ---------------- stage 5: recombine partial products
    ctl_t c5_reg;
    logic [NUM_W-1:0] n5_reg [4];
    logic [DEN_W-1:0] d5_reg [4];
    prd_t e6_5_reg [3];
    prd_t t5_reg   [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c5_reg <= c4_reg;
            for (int k = 0; k < 4; k++)
            begin
                n5_reg[k] <= NUM_W'(nlo_reg[k]) + (NUM_W'(nhi_reg[k]) << HALF_W);
                d5_reg[k] <= DEN_W'(dlo_reg[k]) + (DEN_W'(dhi_reg[k]) << HALF_W);
            end
            for (int k = 0; k < 3; k++)
            begin
                e6_5_reg[k] <= e6_4_reg[k];
                t5_reg[k]   <= t4_reg[k];
            end
        end
    end

    // ---------------- stage 6: pick the fraction for mode and order
    frac_t [NUM_WEIGHTS-1:0] frac_next;

    always_comb
    begin
        for (int k = 0; k < NUM_WEIGHTS; k++)
        begin
            frac_next[k].neg = k[0];
            frac_next[k].num = '0;
            frac_next[k].den = DEN_W'(1);
            if (c5_reg.perr || ORDER_W'(k) >= c5_reg.order)
            begin
                frac_next[k].num = '0;
                frac_next[k].den = DEN_W'(1);
            end
            else if (c5_reg.mode != MODE_ADAPT || c5_reg.order <= ORDER_ONE)
            begin
                frac_next[k].num = NUM_W'(const_num(c5_reg.order, 2'(k)));
                frac_next[k].den = DEN_W'(const_den(c5_reg.order));
            end
            else if (c5_reg.order == ORDER_TWO)
            begin
                frac_next[k].num = (k == 0) ? NUM_W'(c5_reg.o2n0) : NUM_W'(c5_reg.h0);
                frac_next[k].den = DEN_W'(c5_reg.o2d);
            end
            else if (c5_reg.order == ORDER_THREE)
            begin
                if (k < 3)
                begin
                    frac_next[k].num = (k == 0)
                        ? NUM_W'(t5_reg[0]) + NUM_W'(e6_5_reg[0])
                        : NUM_W'(t5_reg[k]);
                    frac_next[k].den = DEN_W'(e6_5_reg[k]);
                end
            end
            else
            begin
                frac_next[k].num = (k == 0) ? n5_reg[0] + NUM_W'(d5_reg[0]) : n5_reg[k];
                frac_next[k].den = d5_reg[k];
            end
        end
    end

    frac_t [NUM_WEIGHTS-1:0] frac_reg;
    logic perr_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            frac_reg <= frac_next;
            perr_reg <= c5_reg.perr;
        end
    end

    assign frac = frac_reg;
    assign perr = perr_reg;

endmodule
`default_nettype wire

@@ hdl/abc_div.sv @@
`default_nettype none
module abc_div (
    input  logic            clk,
    input  logic            adv,
    input  abc_pkg::frac_t  frac,
    output abc_pkg::weight_t weight,
    output logic            sat
);
    import abc_pkg::*;

    // stage a: dividend and divisor
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_a_reg;
    logic             neg_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dvd_reg   <= (DVD_W'(frac.num) << (WEIGHT_FRAC_BITS + 1)) + DVD_W'(frac.den);
            dvs_a_reg <= {frac.den, 1'b0};
            neg_a_reg <= frac.neg;
        end
    end

    // stage b: quotient beyond QB bits means overflow
    logic [CMP_W-1:0] top_ext;
    always_comb
    begin
        top_ext = CMP_W'(dvd_reg[DVD_W-1:QB]);
    end

    logic [DVS_W-1:0] rem_reg [QB+1];
    logic [QB-1:0]    lo_reg  [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];
    logic [DVS_W-1:0] dvs_reg [QB+1];
    logic             ovf_reg [QB+1];
    logic             neg_reg [QB+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ovf_reg[0] <= top_ext >= CMP_W'(dvs_a_reg);
            rem_reg[0] <= top_ext[DVS_W-1:0];
            lo_reg[0]  <= dvd_reg[QB-1:0];
            q_reg[0]   <= '0;
            dvs_reg[0] <= dvs_a_reg;
            neg_reg[0] <= neg_a_reg;
        end
    end

    // one restoring step per stage
    for (genvar i = 0; i < QB; i++)
    begin : g_step
        logic [DVS_W:0] trial;
        logic [DVS_W:0] diff;
        always_comb
        begin
            trial = {rem_reg[i], lo_reg[i][QB-1]};
            diff  = trial - {1'b0, dvs_reg[i]};
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i+1] <= diff[DVS_W] ? trial[DVS_W-1:0] : diff[DVS_W-1:0];
                q_reg[i+1]   <= {q_reg[i][QB-2:0], ~diff[DVS_W]};
                lo_reg[i+1]  <= lo_reg[i] << 1;
                dvs_reg[i+1] <= dvs_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // final: saturate and apply sign
    logic [QB-1:0] limit;
    logic [QB-1:0] mag;
    logic          sat_next;
    always_comb
    begin
        limit    = neg_reg[QB] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
        sat_next = ovf_reg[QB] || (q_reg[QB] > limit);
        mag      = sat_next ? limit : q_reg[QB];
    end

    weight_t weight_reg;
    logic    sat_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            weight_reg <= neg_reg[QB] ? weight_t'(-mag) : weight_t'(mag);
            sat_reg    <= sat_next;
        end
    end

    assign weight = weight_reg;
    assign sat    = sat_reg;

endmodule
`default_nettype wire

@@ hdl/adams_bashforth_coefficients.sv @@
`default_nettype none
// Variable-step Adams-Bashforth weight generator, orders 0 to 4.
// req: mode, order and four step sizes; rsp: four signed Q8.24 weights and
// error_flag. Both are valid/ready channels; a transaction moves when valid
// and ready are high at a clock edge.
// One result per request, in order. The pipeline is made of 6 stages that
// form the numerators and denominators (squares, split cubic products),
// 2 stages that set up the division, 32 restoring steps that produce one
// quotient bit each for all four weights in parallel, and the output stage.
// Throughput is one request per cycle while rsp does not hold a result back.
// The whole pipeline advances together: while rsp holds a result that is
// not taken, every stage holds and req.ready is low; nothing is lost or
// repeated. rst_n (asynchronous, active low) empties the pipeline; no
// clearing pass is needed.
module adams_bashforth_coefficients (
    input  logic      clk,
    input  logic      rst_n,
    abc_req_if.sink   req,
    abc_rsp_if.source rsp
);
    import abc_pkg::*;

    logic adv;
    logic [LAT-1:0] vld_reg;
    logic [DIV_LAT-1:0] perr_pipe_reg;

    assign adv       = !vld_reg[LAT-1] || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], req.valid};
        end
    end

    req_t req_in;
    always_comb
    begin
        req_in.mode  = req.mode;
        req_in.order = req.order;
        req_in.h0    = req.step_now;
        req_in.h1    = req.step_back1;
        req_in.h2    = req.step_back2;
        req_in.h3    = req.step_back3;
    end

    frac_t [NUM_WEIGHTS-1:0] frac;
    logic perr;

    abc_terms u_terms (
        .clk  (clk),
        .adv  (adv),
        .req  (req_in),
        .frac (frac),
        .perr (perr)
    );

    weight_t w [NUM_WEIGHTS];
    logic [NUM_WEIGHTS-1:0] sat;

    for (genvar k = 0; k < NUM_WEIGHTS; k++)
    begin : g_div
        abc_div u_div (
            .clk    (clk),
            .adv    (adv),
            .frac   (frac[k]),
            .weight (w[k]),
            .sat    (sat[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            perr_pipe_reg <= {perr_pipe_reg[DIV_LAT-2:0], perr};
        end
    end

    assign rsp.weight0    = w[0];
    assign rsp.weight1    = w[1];
    assign rsp.weight2    = w[2];
    assign rsp.weight3    = w[3];
    assign rsp.error_flag = perr_pipe_reg[DIV_LAT-1] || (|sat);

endmodule
`default_nettype wire
